### rtl/clcd_pkg.sv
// Shared types, codes and the power-up init strobe table of the character display sequencer.
package clcd_pkg;

	typedef enum logic [2:0] {
		REQ_CMD   = 3'd0,
		REQ_DATA  = 3'd1,
		REQ_CURSOR = 3'd2,
		REQ_CLEAR = 3'd3,
		REQ_INIT  = 3'd4
	} req_code_t;

	localparam logic [2:0] WAIT_NONE       = 3'd0;
	localparam logic [2:0] WAIT_INIT_LONG  = 3'd1;
	localparam logic [2:0] WAIT_INIT_SHORT = 3'd2;
	localparam logic [2:0] WAIT_CMD        = 3'd3;
	localparam logic [2:0] WAIT_CLEAR      = 3'd4;

	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
	localparam logic [7:0] CMD_HOME_ADDR  = 8'h80;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h0F;
	localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
	localparam logic [7:0] ROW2_BASE      = 8'h40;
	localparam logic [7:0] SET_ADDR_BIT   = 8'h80;

	localparam logic [3:0] WAKE_NIBBLE  = 4'h3;
	localparam logic [3:0] MODE4_NIBBLE = 4'h2;

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 4'd1;
	localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd13;

	typedef enum logic [0:0] {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} state_t;

	typedef struct packed {
		logic [3:0] nibble;
		logic       reg_select;
		logic       power_on_wait;
		logic [2:0] wait_after;
		logic       last;
	} strobe_t;

	// Controller to datapath.
	typedef struct packed {
		logic              load;
		logic [STEP_W-1:0] step;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic req_ok;
		logic last;
	} dp_status_t;

	function automatic strobe_t init_strobe(input logic [STEP_W-1:0] step);
		strobe_t s;
		s = '{nibble: WAKE_NIBBLE, reg_select: 1'b0, power_on_wait: 1'b0,
		      wait_after: WAIT_INIT_SHORT, last: 1'b0};
		case (step)
			4'd0: begin
				s.power_on_wait = 1'b1;
				s.wait_after    = WAIT_INIT_LONG;
			end
			4'd1, 4'd2: s.nibble = WAKE_NIBBLE;
			4'd3: s.nibble = MODE4_NIBBLE;
			4'd4: begin
				s.nibble = CMD_FUNC_SET[7:4];
				s.wait_after = WAIT_NONE;
			end
			4'd5: begin
				s.nibble = CMD_FUNC_SET[3:0];
				s.wait_after = WAIT_CMD;
			end
			4'd6: begin
				s.nibble = CMD_CLEAR[7:4];
				s.wait_after = WAIT_NONE;
			end
			4'd7: begin
				s.nibble = CMD_CLEAR[3:0];
				s.wait_after = WAIT_CLEAR;
			end
			4'd8: begin
				s.nibble = CMD_HOME_ADDR[7:4];
				s.wait_after = WAIT_NONE;
			end
			4'd9: begin
				s.nibble = CMD_HOME_ADDR[3:0];
				s.wait_after = WAIT_CMD;
			end
			4'd10: begin
				s.nibble = CMD_DISPLAY_ON[7:4];
				s.wait_after = WAIT_NONE;
			end
			4'd11: begin
				s.nibble = CMD_DISPLAY_ON[3:0];
				s.wait_after = WAIT_CMD;
			end
			4'd12: begin
				s.nibble = CMD_ENTRY_MODE[7:4];
				s.wait_after = WAIT_NONE;
			end
			4'd13: begin
				s.nibble = CMD_ENTRY_MODE[3:0];
				s.wait_after = WAIT_CMD;
				s.last = 1'b1;
			end
			default: begin
				s.nibble = '0;
				s.wait_after = WAIT_NONE;
				s.last = 1'b1;
			end
		endcase
		return s;
	endfunction

endpackage

### rtl/clcd_req_if.sv
// Request channel of the character display sequencer.
interface clcd_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [7:0] data_byte;
	logic [4:0] position;

	modport source(output valid, output req_type, output data_byte, output position,
		input ready);
	modport sink(input valid, input req_type, input data_byte, input position,
		output ready);
endinterface

### rtl/clcd_strobe_if.sv
// Strobe channel of the character display sequencer: one item per enable strobe.
interface clcd_strobe_if;
	logic       valid;
	logic       ready;
	logic [3:0] nibble;
	logic       reg_select;
	logic       power_on_wait;
	logic [2:0] wait_after;
	logic       last;

	modport source(output valid, output nibble, output reg_select, output power_on_wait,
		output wait_after, output last, input ready);
	modport sink(input valid, input nibble, input reg_select, input power_on_wait,
		input wait_after, input last, output ready);
endinterface

### rtl/clcd_ctrl.sv
// Controller: takes a request, then steps through its strobes one per taken output.
module clcd_ctrl
	import clcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		req_ready = 1'b0;
		out_valid = 1'b0;
		cmd.load  = 1'b0;
		cmd.step  = step_q;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				// Unused request codes are taken and dropped without any strobe.
				if (req_valid && status.req_ok) begin
					cmd.load = 1'b1;
					step_d   = '0;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (status.last) begin
						state_d = ST_IDLE;
					end else begin
						step_d = step_q + 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### rtl/clcd_datapath.sv
// Datapath: latches the request, forms the byte to send and builds each strobe.
module clcd_datapath
	import clcd_pkg::*;
#(
	parameter int COLUMNS = 16
) (
	input  logic       clk,
	input  logic [2:0] req_type,
	input  logic [7:0] data_byte,
	input  logic [4:0] position,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output strobe_t    strobe
);

	localparam logic [5:0] COLS = 6'(COLUMNS);

	logic       init_q;
	logic       clear_q;
	logic       rs_q;
	logic [7:0] byte_q;
	logic [7:0] byte_d;
	logic [7:0] addr;
	strobe_t    byte_strobe;

	// Second-row cells count up from the row base; the sum is kept to 8 bits.
	always_comb begin
		if ({1'b0, position} >= COLS) begin
			addr = ROW2_BASE + 8'(position) - 8'(COLS);
		end else begin
			addr = 8'(position);
		end
	end

	always_comb begin
		case (req_type)
			REQ_CURSOR: byte_d = addr | SET_ADDR_BIT;
			REQ_CLEAR:  byte_d = CMD_CLEAR;
			default:    byte_d = data_byte;
		endcase
	end

	assign status.req_ok = (req_type == REQ_CMD) || (req_type == REQ_DATA)
		|| (req_type == REQ_CURSOR) || (req_type == REQ_CLEAR) || (req_type == REQ_INIT);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			init_q  <= (req_type == REQ_INIT);
			clear_q <= (req_type == REQ_CLEAR);
			rs_q    <= (req_type == REQ_DATA);
			byte_q  <= byte_d;
		end
	end

	always_comb begin
		byte_strobe.reg_select    = rs_q;
		byte_strobe.power_on_wait = 1'b0;
		if (cmd.step == BYTE_LAST_STEP) begin
			byte_strobe.nibble     = byte_q[3:0];
			byte_strobe.wait_after = clear_q ? WAIT_CLEAR : WAIT_NONE;
			byte_strobe.last       = 1'b1;
		end else begin
			byte_strobe.nibble     = byte_q[7:4];
			byte_strobe.wait_after = WAIT_NONE;
			byte_strobe.last       = 1'b0;
		end
	end

	assign strobe      = init_q ? init_strobe(cmd.step) : byte_strobe;
	assign status.last = strobe.last;

endmodule

### rtl/char_lcd_4bit_sequencer_core.sv
// A request is taken while idle; its first strobe is offered the next cycle.
// Throughput: one strobe per cycle while the sink takes them; a byte request sends
// 2 strobes, power-up init 14 strobes.
// A new request is taken only once the last strobe of the previous one has gone out.
// Reset: arst_n clears the controller to idle; no strobe is pending after reset.
// The request latch in the datapath holds no reset value.
module char_lcd_4bit_sequencer_core
	import clcd_pkg::*;
#(
	parameter int COLUMNS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	clcd_req_if.sink      req,
	clcd_strobe_if.source strobe
);

	dp_cmd_t    cmd;
	dp_status_t status;
	strobe_t    strobe_data;

	clcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.out_valid (strobe.valid),
		.out_ready (strobe.ready),
		.status    (status),
		.cmd       (cmd)
	);

	clcd_datapath #(
		.COLUMNS (COLUMNS)
	) u_datapath (
		.clk       (clk),
		.req_type  (req.req_type),
		.data_byte (req.data_byte),
		.position  (req.position),
		.cmd       (cmd),
		.status    (status),
		.strobe    (strobe_data)
	);

	assign strobe.nibble        = strobe_data.nibble;
	assign strobe.reg_select    = strobe_data.reg_select;
	assign strobe.power_on_wait = strobe_data.power_on_wait;
	assign strobe.wait_after    = strobe_data.wait_after;
	assign strobe.last          = strobe_data.last;

endmodule
